// ===== sv/hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types and constants of the handoff retransmit tracker.
// ----------------------------------------------------------------------------
package hrt_pkg;

  // Table geometry.
  localparam int unsigned SLOTS  = 8;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // Field widths fixed by the interface.
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned FACE_W = 2;
  localparam int unsigned PAY_W  = 16;
  localparam int unsigned RTY_W  = 4;
  localparam int unsigned IVL_W  = 16;

  // Output port widths fixed by the interface.
  localparam int unsigned SLOT_OUT_W = 3;
  localparam int unsigned FREE_OUT_W = 4;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 1'b1;

  localparam logic [IVL_W-1:0] RETRY_INTERVAL_RST = 16'd500;
  localparam logic [RTY_W-1:0] RETRY_LIMIT_RST    = 4'd3;

  // Two-entry queues used between the parts.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_SERVICE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACCEPTED    = 3'd0,
    KIND_REFUSED     = 3'd1,
    KIND_ACK_MATCHED = 3'd2,
    KIND_ACK_MISSED  = 3'd3,
    KIND_RESEND      = 3'd4,
    KIND_TIMED_OUT   = 3'd5,
    KIND_NOTHING_DUE = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now_ms;
    logic [FACE_W-1:0] face;
    logic [PAY_W-1:0]  payload;
    logic [SEQ_W-1:0]  ack_seq;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  slot;
    logic [SEQ_W-1:0]  seq;
    logic [FACE_W-1:0] face;
    logic [PAY_W-1:0]  payload;
    logic [RTY_W-1:0]  retries;
    logic [CNT_W-1:0]  free_cnt;
    logic              last;
  } res_t;

endpackage

// ===== sv/handoff_retransmit_tracker_top.sv =====
// ----------------------------------------------------------------------------
// handoff_retransmit_tracker_top
// Sender-side acknowledgement, retransmit and timeout table.
// ----------------------------------------------------------------------------
// The block keeps a table of eight outstanding transfers. A send transaction
// claims the lowest free slot and stamps it with the next 16-bit sequence
// number, the face, the payload handle and the send time; an ack transaction
// frees the lowest active slot whose sequence matches; a service transaction
// walks the slots in order and resends or times out every slot whose wait
// has reached the retry interval. Each input transaction yields one result
// transaction, or for a service one per due slot (one nothing-due result if
// none is due), and the final result of an input carries last_o high.
// Action code 3 is dropped on entry and yields nothing. Inputs enter a
// two-entry command queue; results leave through a two-entry result queue,
// so the input side keeps taking transactions while results wait to be
// popped. Commands are carried out one at a time by a sequencer that visits
// one slot per cycle unless held by a full result queue: it loads a
// command, visits the slots in order (up to eight; a send or an ack stops at
// its slot) and releases the final result. The user must write the retry
// interval and retry limit registers through the cfg_* port only while no
// transaction is in flight; the block does not check. Reset: 500 ms and 3.
// ----------------------------------------------------------------------------
module handoff_retransmit_tracker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hrt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hrt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        action_i,
  input  logic [hrt_pkg::TIME_W-1:0]         now_ms_i,
  input  logic [hrt_pkg::FACE_W-1:0]         target_face_i,
  input  logic [hrt_pkg::PAY_W-1:0]          payload_handle_i,
  input  logic [hrt_pkg::SEQ_W-1:0]          ack_sequence_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        kind_o,
  output logic [hrt_pkg::SLOT_OUT_W-1:0]     slot_index_o,
  output logic [hrt_pkg::SEQ_W-1:0]          sequence_res_o,
  output logic [hrt_pkg::FACE_W-1:0]         out_face_o,
  output logic [hrt_pkg::PAY_W-1:0]          out_payload_handle_o,
  output logic [hrt_pkg::RTY_W-1:0]          retry_count_o,
  output logic [hrt_pkg::FREE_OUT_W-1:0]     free_count_o,
  output logic                              last_o
);
  import hrt_pkg::*;

  // Command path from the front part to the sequencer.
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Result path from the sequencer to the output queue.
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  hrt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .now_ms_i         (now_ms_i),
    .target_face_i    (target_face_i),
    .payload_handle_i (payload_handle_i),
    .ack_sequence_i   (ack_sequence_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  hrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  hrt_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  // The oldest waiting result drives the result ports.
  assign kind_o               = res_out.kind;
  assign slot_index_o         = SLOT_OUT_W'(res_out.slot);
  assign sequence_res_o       = res_out.seq;
  assign out_face_o           = res_out.face;
  assign out_payload_handle_o = res_out.payload;
  assign retry_count_o        = res_out.retries;
  assign free_count_o         = FREE_OUT_W'(res_out.free_cnt);
  assign last_o               = res_out.last;

endmodule

// ===== sv/hrt_front.sv =====
// ----------------------------------------------------------------------------
// hrt_front
// Accepts input transactions, classifies the action and queues commands.
// ----------------------------------------------------------------------------
module hrt_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                action_i,
  input  logic [hrt_pkg::TIME_W-1:0] now_ms_i,
  input  logic [hrt_pkg::FACE_W-1:0] target_face_i,
  input  logic [hrt_pkg::PAY_W-1:0]  payload_handle_i,
  input  logic [hrt_pkg::SEQ_W-1:0]  ack_sequence_i,
  output logic                      cmd_valid_o,
  output hrt_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);
  import hrt_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              keep;
  logic              wr_en;
  logic              rd_en;
  cmd_t              cmd_in;

  // Action code 3 carries no meaning and is dropped on entry.
  assign keep = (action_i inside {OP_SEND, OP_ACK, OP_SERVICE});

  always_comb begin
    cmd_in.op      = op_e'(action_i);
    cmd_in.now_ms  = now_ms_i;
    cmd_in.face    = target_face_i;
    cmd_in.payload = payload_handle_i;
    cmd_in.ack_seq = ack_sequence_i;
  end

  assign full        = (cnt_q == QCNT_W'(QDEPTH));
  assign wr_en       = push && !full && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== sv/hrt_res_queue.sv =====
// ----------------------------------------------------------------------------
// hrt_res_queue
// Two-entry result queue that decouples the table sequencer from the reader.
// ----------------------------------------------------------------------------
module hrt_res_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hrt_pkg::res_t res_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output hrt_pkg::res_t res_o
);
  import hrt_pkg::*;

  res_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              wr_en;
  logic              rd_en;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign res_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== sv/hrt_back.sv =====
// ----------------------------------------------------------------------------
// hrt_back
// Slot table, configuration registers and the scan sequencer that carries out
// one command at a time, one slot per cycle unless stalled by a full queue.
// ----------------------------------------------------------------------------
module hrt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hrt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          cmd_valid_i,
  input  hrt_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic                          res_push_o,
  output hrt_pkg::res_t                 res_o,
  input  logic                          res_full_i
);
  import hrt_pkg::*;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  res_t              pend_q, pend_d;
  logic              pend_valid_q, pend_valid_d;
  logic [SEQ_W-1:0]  next_seq_q, next_seq_d;
  logic [IVL_W-1:0]  interval_q;
  logic [RTY_W-1:0]  limit_q;

  logic [SLOTS-1:0]  active_q;
  logic [SEQ_W-1:0]  seq_q     [SLOTS];
  logic [FACE_W-1:0] face_q    [SLOTS];
  logic [PAY_W-1:0]  payload_q [SLOTS];
  logic [TIME_W-1:0] sent_q    [SLOTS];
  logic [RTY_W-1:0]  retries_q [SLOTS];

  logic              cur_active;
  logic [SEQ_W-1:0]  cur_seq;
  logic [RTY_W-1:0]  cur_retries;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              last_idx;
  logic [CNT_W-1:0]  free_now;

  logic              new_res;
  res_t              new_val;
  logic              done;
  logic              stall;
  logic              wr_fill;
  logic              wr_renew;
  logic              wr_clear;

  assign cur_active  = active_q[idx_q];
  assign cur_seq     = seq_q[idx_q];
  assign cur_retries = retries_q[idx_q];
  assign elapsed     = cmd_q.now_ms - sent_q[idx_q];
  assign due         = cur_active && (elapsed >= TIME_W'(interval_q));
  assign last_idx    = (idx_q == IDX_W'(SLOTS - 1));
  assign free_now    = CNT_W'($countones(~active_q));

  // Per-slot decision of the command in hand.
  always_comb begin
    new_res          = 1'b0;
    done             = 1'b0;
    wr_fill          = 1'b0;
    wr_renew         = 1'b0;
    wr_clear         = 1'b0;
    new_val.kind     = KIND_NOTHING_DUE;
    new_val.slot     = idx_q;
    new_val.seq      = cur_seq;
    new_val.face     = face_q[idx_q];
    new_val.payload  = payload_q[idx_q];
    new_val.retries  = cur_retries;
    new_val.free_cnt = free_now;
    new_val.last     = 1'b0;
    case (cmd_q.op)
      OP_SEND: begin
        if (!cur_active) begin
          new_res          = 1'b1;
          done             = 1'b1;
          wr_fill          = 1'b1;
          new_val.kind     = KIND_ACCEPTED;
          new_val.seq      = next_seq_q;
          new_val.face     = cmd_q.face;
          new_val.payload  = cmd_q.payload;
          new_val.retries  = '0;
          new_val.free_cnt = free_now - 1'b1;
        end else if (last_idx) begin
          new_res         = 1'b1;
          done            = 1'b1;
          new_val.kind    = KIND_REFUSED;
          new_val.slot    = '0;
          new_val.seq     = '0;
          new_val.face    = '0;
          new_val.payload = '0;
          new_val.retries = '0;
        end
      end
      OP_ACK: begin
        if (cur_active && (cur_seq == cmd_q.ack_seq)) begin
          new_res          = 1'b1;
          done             = 1'b1;
          wr_clear         = 1'b1;
          new_val.kind     = KIND_ACK_MATCHED;
          new_val.free_cnt = free_now + 1'b1;
        end else if (last_idx) begin
          new_res         = 1'b1;
          done            = 1'b1;
          new_val.kind    = KIND_ACK_MISSED;
          new_val.slot    = '0;
          new_val.seq     = cmd_q.ack_seq;
          new_val.face    = '0;
          new_val.payload = '0;
          new_val.retries = '0;
        end
      end
      OP_SERVICE: begin
        done = last_idx;
        if (due) begin
          new_res = 1'b1;
          if (cur_retries < limit_q) begin
            wr_renew        = 1'b1;
            new_val.kind    = KIND_RESEND;
            new_val.retries = cur_retries + 1'b1;
          end else begin
            wr_clear         = 1'b1;
            new_val.kind     = KIND_TIMED_OUT;
            new_val.free_cnt = free_now + 1'b1;
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // A new result can only displace the held one when the queue has room.
  assign stall = (state_q == ST_SCAN) && new_res && pend_valid_q && res_full_i;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    next_seq_d   = next_seq_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o        = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          cmd_d        = cmd_i;
          idx_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (new_res) begin
            res_push_o   = pend_valid_q;
            pend_d       = new_val;
            pend_valid_d = 1'b1;
          end
          if (wr_fill) begin
            next_seq_d = next_seq_q + 1'b1;
          end
          if (done) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_valid_q) begin
          res_o.last = 1'b1;
        end else begin
          res_o.kind     = KIND_NOTHING_DUE;
          res_o.slot     = '0;
          res_o.seq      = '0;
          res_o.face     = '0;
          res_o.payload  = '0;
          res_o.retries  = '0;
          res_o.free_cnt = free_now;
          res_o.last     = 1'b1;
        end
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      next_seq_q   <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      next_seq_q   <= next_seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= RETRY_INTERVAL_RST;
      limit_q    <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RETRY_INTERVAL: interval_q <= cfg_wdata_i[IVL_W-1:0];
        CFG_RETRY_LIMIT:    limit_q    <= cfg_wdata_i[RTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if ((state_q == ST_SCAN) && !stall) begin
      if (wr_fill) begin
        active_q[idx_q] <= 1'b1;
      end else if (wr_clear) begin
        active_q[idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && !stall) begin
      if (wr_fill) begin
        seq_q[idx_q]     <= next_seq_q;
        face_q[idx_q]    <= cmd_q.face;
        payload_q[idx_q] <= cmd_q.payload;
        sent_q[idx_q]    <= cmd_q.now_ms;
        retries_q[idx_q] <= '0;
      end else if (wr_renew) begin
        sent_q[idx_q]    <= cmd_q.now_ms;
        retries_q[idx_q] <= cur_retries + 1'b1;
      end
    end
  end

  // A held result is always released before the sequencer goes idle.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("held result left behind in idle");

  // Only an accepted send advances the sequence counter.
  a_seq_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((state_q == ST_SCAN) && (cmd_q.op == OP_SEND)) |=> $stable(next_seq_q))
    else $error("sequence number moved outside a send");

  // Results are never pushed into a full queue.
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  // Every command leaves through the flush state with exactly one final result.
  a_flush_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (state_q == ST_SCAN)) |-> !res_o.last)
    else $error("final marker set on an intermediate result");

endmodule
